@@ rtl/cba_pkg.sv @@
// cba_pkg: shared types and constants of the chunked block allocator
// word layouts, status and mode codes, per-chunk record type
// no dependencies
package cba_pkg;

    localparam int COUNT_W = 9;
    localparam int CHUNK_W = 4;
    localparam int BLOCK_W = 8;
    localparam int LINK_W  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] STACK_EMPTY = 9'd256;
    localparam logic [COUNT_W-1:0] BPC_RESET   = 9'd256;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCKS_PER_CHUNK = 1'b0;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [CHUNK_W-1:0] free_chunk;
        logic [BLOCK_W-1:0] free_block;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [CHUNK_W-1:0] given_chunk;
        logic [BLOCK_W-1:0] given_block;
        logic               chunk_released;
    } t_out_word;

    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] head;
        logic [COUNT_W-1:0] fresh;
    } t_meta;

    typedef struct packed {
        logic  we;
        logic  hint_we;
        t_meta meta;
    } t_meta_upd;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

@@ rtl/cba_link_ram.sv @@
// cba_link_ram: link word memory, one write and one read port
// registered read data; uses cba_pkg
module cba_link_ram
    import cba_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [LINK_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [LINK_W-1:0] o_rdata
);

    logic [LINK_W-1:0] r_mem [DEPTH];
    logic [LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cba_chunk_table.sv @@
// cba_chunk_table: per-chunk records, allocation hint, per-chunk flags
// uses cba_pkg
module cba_chunk_table
    import cba_pkg::*;
#(
    parameter int NUM_CHUNKS = 16,
    parameter int MAX_BLOCKS = 256,
    parameter int CW         = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_nb,
    input  t_meta_upd          i_upd,
    input  logic [CW-1:0]      i_upd_idx,
    input  logic [CW-1:0]      i_upd_hint,
    output t_meta              o_meta [NUM_CHUNKS],
    output logic [CW-1:0]      o_hint,
    output logic [NUM_CHUNKS-1:0] o_can_give,
    output logic [NUM_CHUNKS-1:0] o_full
);

    localparam logic [COUNT_W-1:0] MAX_B = COUNT_W'(MAX_BLOCKS);

    t_meta         r_meta [NUM_CHUNKS];
    logic [CW-1:0] r_hint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHUNKS; c++) begin
                r_meta[c] <= '{active: 1'b0, count: '0, head: STACK_EMPTY, fresh: '0};
            end
            r_hint <= '0;
        end else begin
            if (i_upd.we) begin
                r_meta[i_upd_idx] <= i_upd.meta;
            end
            if (i_upd.hint_we) begin
                r_hint <= i_upd_hint;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            o_meta[c]     = r_meta[c];
            o_can_give[c] = r_meta[c].active && (r_meta[c].count != '0) &&
                            ((r_meta[c].head != STACK_EMPTY) || (r_meta[c].fresh < MAX_B));
            o_full[c]     = r_meta[c].active && (r_meta[c].count >= i_nb);
        end
    end

    assign o_hint = r_hint;

endmodule

@@ rtl/chunked_block_allocator_core.sv @@
// chunked_block_allocator_core: top level of the chunked block allocator
// control sequencer, config register, output register; uses cba_pkg,
// cba_chunk_table and cba_link_ram
//
// Fixed-size block allocator over NUM_CHUNKS chunk slots of up to MAX_BLOCKS
// blocks. Each input word is an allocate (mode 0) or a free (mode 1); each
// gives exactly one output word. A word is accepted in ST_IDLE, then finished in
// ST_UPDATE. On accept the chunk is chosen and, for an allocate, the link memory
// is read at that chunk's free list head. ST_UPDATE uses the read data, writes
// back the chunk record and, for a free, the link word once the output is free.
// The registered link memory read and each word's dependence on the free-list
// head left by the last one allow one word at a time. Results sit in an output
// register; when it is still held by i_out_stall the update cycle waits until it
// drains. The link memory needs no clearing pass, so the block takes words right
// after reset. blocks_per_chunk is written at byte address 0 over the apb port
// and must only change while the block is idle.
module chunked_block_allocator_core
    import cba_pkg::*;
#(
    parameter int NUM_CHUNKS = 16,
    parameter int MAX_BLOCKS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    // apb config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int DEPTH = NUM_CHUNKS * MAX_BLOCKS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] MAX_B = COUNT_W'(MAX_BLOCKS);
    localparam logic [COUNT_W-1:0] NUM_C = COUNT_W'(NUM_CHUNKS);

    // ---------------------------------------------------------------
    // config register
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] r_bpc;
    logic [COUNT_W-1:0] nb;
    logic               cfg_hit;

    assign cfg_hit = (paddr[2] == REG_BLOCKS_PER_CHUNK);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc <= BPC_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_bpc <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = cfg_hit ? APB_DATA_W'(r_bpc) : '0;

    // zero acts as one, anything above the chunk size is clipped
    always_comb begin
        if (r_bpc == '0) begin
            nb = COUNT_W'(1);
        end else if (r_bpc > MAX_B) begin
            nb = MAX_B;
        end else begin
            nb = r_bpc;
        end
    end

    // ---------------------------------------------------------------
    // chunk records
    // ---------------------------------------------------------------
    t_meta                 meta [NUM_CHUNKS];
    logic [CW-1:0]         hint;
    logic [NUM_CHUNKS-1:0] can_give;
    logic [NUM_CHUNKS-1:0] full;
    t_meta_upd             upd;
    logic [CW-1:0]         upd_idx;
    logic [CW-1:0]         upd_hint;

    cba_chunk_table #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .CW         (CW)
    ) u_chunk_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nb       (nb),
        .i_upd      (upd),
        .i_upd_idx  (upd_idx),
        .i_upd_hint (upd_hint),
        .o_meta     (meta),
        .o_hint     (hint),
        .o_can_give (can_give),
        .o_full     (full)
    );

    // ---------------------------------------------------------------
    // link memory
    // ---------------------------------------------------------------
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [LINK_W-1:0] mem_rdata;

    cba_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // chunk choice for an allocate, evaluated on the accept cycle
    // ---------------------------------------------------------------
    logic          give_found;
    logic [CW-1:0] give_idx;
    logic          inact_found;
    logic [CW-1:0] inact_idx;
    logic          hint_ok;
    logic [CW-1:0] pick;
    logic          pick_new;
    logic          pick_fail;

    // lowest index wins: scan from the top down
    always_comb begin
        give_found  = 1'b0;
        give_idx    = '0;
        inact_found = 1'b0;
        inact_idx   = '0;
        for (int c = NUM_CHUNKS - 1; c >= 0; c--) begin
            if (can_give[c]) begin
                give_found = 1'b1;
                give_idx   = CW'(c);
            end
            if (!meta[c].active) begin
                inact_found = 1'b1;
                inact_idx   = CW'(c);
            end
        end
    end

    assign hint_ok = can_give[hint];

    always_comb begin
        pick      = '0;
        pick_new  = 1'b0;
        pick_fail = 1'b0;
        if (hint_ok) begin
            pick = hint;
        end else if (give_found) begin
            pick = give_idx;
        end else if (inact_found) begin
            pick     = inact_idx;
            pick_new = 1'b1;
        end else begin
            pick_fail = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    t_state          r_state;
    t_state          n_state;
    logic            in_accept;
    logic            out_free;
    logic            finish;

    logic            r_mode;
    logic [CHUNK_W-1:0] r_fc;
    logic [BLOCK_W-1:0] r_fb;
    logic [CW-1:0]   r_pick;
    logic            r_new;
    logic            r_fail;

    logic            r_out_valid;
    t_out_word       r_out_word;
    t_out_word       n_out_word;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mem_re  = 1'b0;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_UPDATE;
                    mem_re  = (i_in_word.mode == MODE_ALLOC);
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    finish  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read address: head of the chosen chunk's free list
    assign mem_raddr = AW'(pick) * AW'(MAX_BLOCKS) + AW'(meta[pick].head[BW-1:0]);

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_in_word.mode;
            r_fc   <= i_in_word.free_chunk;
            r_fb   <= i_in_word.free_block;
            r_pick <= pick;
            r_new  <= pick_new;
            r_fail <= pick_fail;
        end
    end

    // ---------------------------------------------------------------
    // update cycle: record rewrite, link write, result
    // ---------------------------------------------------------------
    logic               fc_ok;
    logic [CW-1:0]      fc_idx;
    t_meta              fm;
    t_meta              am;
    logic [COUNT_W-1:0] cnt_dec;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] nxt;
    logic [COUNT_W-1:0] push_link;
    logic               bad_free;
    logic               other_found;
    logic [CW-1:0]      other_idx;

    assign fc_ok  = (COUNT_W'(r_fc) < NUM_C);
    assign fc_idx = fc_ok ? CW'(r_fc) : '0;
    assign fm     = meta[fc_idx];

    // a newly activated chunk starts with a full count and no stack
    assign am = r_new ? t_meta'{active: 1'b1, count: nb, head: STACK_EMPTY, fresh: '0}
                      : meta[r_pick];

    assign cnt_dec   = am.count - COUNT_W'(1);
    assign cnt_inc   = fm.count + COUNT_W'(1);
    assign nxt       = COUNT_W'(mem_rdata);
    assign push_link = (fm.head == STACK_EMPTY) ? fm.fresh : fm.head;

    assign bad_free = !fc_ok || !fm.active || (COUNT_W'(r_fb) >= nb) ||
                      (COUNT_W'(r_fb) >= fm.fresh) || (fm.count >= nb);

    // another fully free chunk, lowest index, the freed one excluded
    always_comb begin
        other_found = 1'b0;
        other_idx   = '0;
        for (int c = NUM_CHUNKS - 1; c >= 0; c--) begin
            if (full[c] && (CW'(c) != fc_idx)) begin
                other_found = 1'b1;
                other_idx   = CW'(c);
            end
        end
    end

    assign mem_waddr = AW'(fc_idx) * AW'(MAX_BLOCKS) + AW'(r_fb[BW-1:0]);
    assign mem_wdata = push_link[LINK_W-1:0];

    always_comb begin
        upd        = '0;
        upd.meta   = am;
        upd_idx    = r_pick;
        upd_hint   = r_pick;
        mem_we     = 1'b0;
        n_out_word = '0;
        if (r_mode == MODE_ALLOC) begin
            if (r_fail) begin
                n_out_word.status = STATUS_NO_SLOT;
            end else begin
                upd.we            = finish;
                upd.hint_we       = finish;
                upd.meta.count    = cnt_dec;
                n_out_word.status = STATUS_OK;
                n_out_word.given_chunk = CHUNK_W'(r_pick);
                if (am.head < MAX_B) begin
                    // pop: stack ends at the watermark or when the count runs out
                    n_out_word.given_block = am.head[BLOCK_W-1:0];
                    upd.meta.head = ((cnt_dec == '0) || (nxt >= am.fresh)) ? STACK_EMPTY
                                                                           : nxt;
                end else begin
                    n_out_word.given_block = am.fresh[BLOCK_W-1:0];
                    upd.meta.fresh = am.fresh + COUNT_W'(1);
                end
            end
        end else begin
            upd_idx  = fc_idx;
            upd.meta = fm;
            if (bad_free) begin
                n_out_word.status = STATUS_BAD_FREE;
            end else begin
                n_out_word.status = STATUS_OK;
                mem_we            = finish;
                upd.we            = finish;
                upd.meta.head     = COUNT_W'(r_fb);
                upd.meta.count    = cnt_inc;
                if (cnt_inc >= nb) begin
                    upd.hint_we = finish;
                    if (other_found) begin
                        // keep only one fully free chunk
                        upd.meta = '{active: 1'b0, count: '0, head: STACK_EMPTY, fresh: '0};
                        upd_hint = other_idx;
                        n_out_word.chunk_released = 1'b1;
                    end else begin
                        upd_hint = fc_idx;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/cba_checker.sv @@
// cba_checker: port-level assertions for chunked_block_allocator_core
// bound to the top level below; uses cba_pkg
module cba_checker
    import cba_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // held result word does not move
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // failed words carry no block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != STATUS_OK) |->
            (o_out_word.given_chunk == '0) && (o_out_word.given_block == '0) &&
            !o_out_word.chunk_released)
        else $error("failed result carries data");

    // a release only comes from a good free
    a_release_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.chunk_released |->
            (o_out_word.status == STATUS_OK) && (o_out_word.given_chunk == '0) &&
            (o_out_word.given_block == '0))
        else $error("chunk release on a non-free result");

    // one word at a time: busy after each accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted a word back to back");

endmodule

bind chunked_block_allocator_core cba_checker u_cba_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for chunked_block_allocator_core
// directed plan then random phases, checked against an in-bench allocator shadow
// depends on cba_pkg and chunked_block_allocator_core
module tb_top;
    import cba_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int N_SLOTS     = 16;
    localparam int SLOT_BLOCKS = 256;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 50;
    localparam int HOLD_CYCLES = 60;

    // kinds of row in the directed plan
    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_in_word   word;
        logic [8:0] cfg;
        logic       typed;
        t_out_word  want;
    } t_plan_row;

    // clock, reset and every block input start at known values
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_word              i_in_word  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow copy of the allocator state, indexed like the block's own tables
    logic       chunk_on   [N_SLOTS];
    logic [8:0] chunk_left [N_SLOTS];
    logic [8:0] chunk_top  [N_SLOTS];
    logic [8:0] chunk_mark [N_SLOTS];
    logic [7:0] chain_word [N_SLOTS*SLOT_BLOCKS];
    logic [3:0] next_pick;
    logic [8:0] block_count_reg;

    // result words owed by the block, oldest first
    t_out_word  replies_due[$];
    // handles currently held by the bench, ready to be freed
    t_in_word   freeable[$];
    t_in_word   last_freed;
    bit         have_last = 1'b0;
    t_plan_row  plan[$];

    int mismatches  = 0;
    int words_seen  = 0;
    int n_requests  = 0;
    int n_alloc_ok  = 0;
    int n_no_slot   = 0;
    int n_free_ok   = 0;
    int n_bad_free  = 0;
    int n_released  = 0;

    // long receiver hold-off, asked for by the sender, counted by the stall process
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int holds_done = 0;

    chunked_block_allocator_core #(
        .NUM_CHUNKS(N_SLOTS),
        .MAX_BLOCKS(SLOT_BLOCKS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // a chunk can hand out a block when active, counted non-empty, and either
    // its stack holds something or fresh blocks remain below the slot size
    function automatic bit chunk_can_give(input int c);
        return chunk_on[c] && chunk_left[c] != 0 &&
               (chunk_top[c] != STACK_EMPTY || chunk_mark[c] < SLOT_BLOCKS);
    endfunction

    // advance the shadow allocator by one request word and return its reply
    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word  r;
        int         nb;
        int         pick;
        int         other;
        int         c;
        int         b;
        int         fc;
        int         fb;
        logic [8:0] nxt;
        r = '0;
        // register out of range: zero acts as one, anything above the slot size clamps
        nb = (block_count_reg == 0) ? 1 :
             ((block_count_reg > SLOT_BLOCKS) ? SLOT_BLOCKS : block_count_reg);
        if (w.mode == MODE_ALLOC) begin
            pick = N_SLOTS;
            if (chunk_can_give(next_pick))
                pick = next_pick;
            for (c = 0; c < N_SLOTS && pick == N_SLOTS; c++)
                if (chunk_can_give(c))
                    pick = c;
            if (pick == N_SLOTS) begin
                for (c = 0; c < N_SLOTS && pick == N_SLOTS; c++)
                    if (!chunk_on[c])
                        pick = c;
                if (pick == N_SLOTS) begin
                    r.status = STATUS_NO_SLOT;
                    return r;
                end
                chunk_on[pick]   = 1'b1;
                chunk_left[pick] = 9'(nb);
                chunk_top[pick]  = STACK_EMPTY;
                chunk_mark[pick] = '0;
            end
            next_pick = pick[3:0];
            chunk_left[pick] = chunk_left[pick] - 9'd1;
            if (chunk_top[pick] != STACK_EMPTY) begin
                // pop; the bottom link holds the watermark, which ends the stack
                b = chunk_top[pick];
                nxt = {1'b0, chain_word[pick*SLOT_BLOCKS + b]};
                chunk_top[pick] = (chunk_left[pick] == 0 || nxt >= chunk_mark[pick]) ?
                                  STACK_EMPTY : nxt;
            end else begin
                b = chunk_mark[pick];
                chunk_mark[pick] = chunk_mark[pick] + 9'd1;
            end
            r.given_chunk = pick[3:0];
            r.given_block = b[7:0];
        end else begin
            fc = w.free_chunk;
            fb = w.free_block;
            if (!chunk_on[fc] || fb >= nb || fb >= chunk_mark[fc] || chunk_left[fc] >= nb) begin
                r.status = STATUS_BAD_FREE;
                return r;
            end
            chain_word[fc*SLOT_BLOCKS + fb] = (chunk_top[fc] == STACK_EMPTY) ?
                                              chunk_mark[fc][7:0] : chunk_top[fc][7:0];
            chunk_top[fc]  = 9'(fb);
            chunk_left[fc] = chunk_left[fc] + 9'd1;
            if (chunk_left[fc] >= nb) begin
                // only one fully free chunk may stay active
                other = N_SLOTS;
                for (c = 0; c < N_SLOTS && other == N_SLOTS; c++)
                    if (c != fc && chunk_on[c] && chunk_left[c] >= nb)
                        other = c;
                if (other != N_SLOTS) begin
                    chunk_on[fc]   = 1'b0;
                    chunk_left[fc] = '0;
                    chunk_top[fc]  = STACK_EMPTY;
                    chunk_mark[fc] = '0;
                    next_pick = other[3:0];
                    r.chunk_released = 1'b1;
                end else begin
                    next_pick = fc[3:0];
                end
            end
        end
        return r;
    endfunction

    // offer one request word, hold it until taken, then log what it is owed
    task automatic send_request(input t_in_word w, input logic typed, input t_out_word want);
        t_out_word got;
        t_in_word  fw;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        got = apply_request(w);
        replies_due = {replies_due, (typed ? want : got)};
        n_requests++;
        if (w.mode == MODE_ALLOC) begin
            if (got.status == STATUS_OK) begin
                n_alloc_ok++;
                fw.mode       = MODE_FREE;
                fw.free_chunk = got.given_chunk;
                fw.free_block = got.given_block;
                freeable = {freeable, fw};
            end else begin
                n_no_slot++;
            end
        end else if (got.status == STATUS_OK) begin
            n_free_ok++;
            if (got.chunk_released)
                n_released++;
        end else begin
            n_bad_free++;
        end
    endtask

    // stop offering and wait until every owed word came back, plus a short settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write of blocks_per_chunk, then read it back in a second transfer
    task automatic write_block_count(input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BLOCKS_PER_CHUNK, 2'b00};
        pwdata  <= {{(APB_DATA_W-9){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        block_count_reg = value;
        // back-to-back read setup, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[8:0] !== value) begin
            $display("%0t: mismatch on blocks_per_chunk readback, expected %0d, actual %0d",
                     $time, value, prdata[8:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic plan_cfg(input logic [8:0] value);
        t_plan_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg  = value;
        plan = {plan, row};
    endtask

    // typed rows always carry a zero handle, so only status and release are given
    task automatic plan_req(input logic m, input logic [3:0] ch, input logic [7:0] bl,
                            input logic typed, input logic [1:0] st, input logic rel);
        t_plan_row row;
        row = '0;
        row.kind                = ROW_WORD;
        row.word.mode           = m;
        row.word.free_chunk     = ch;
        row.word.free_block     = bl;
        row.typed               = typed;
        row.want.status         = st;
        row.want.chunk_released = rel;
        plan = {plan, row};
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result side: every taken word is matched against the oldest owed one
    always @(posedge i_clk) begin
        t_out_word owed;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            words_seen++;
            if (replies_due.size() == 0) begin
                $display("%0t: mismatch, expected no word, actual %h", $time, o_out_word);
                mismatches++;
            end else begin
                owed = replies_due.pop_front();
                check_field("status", owed.status, o_out_word.status);
                check_field("given_chunk", owed.given_chunk, o_out_word.given_chunk);
                check_field("given_block", owed.given_block, o_out_word.given_block);
                check_field("chunk_released", owed.chunk_released, o_out_word.chunk_released);
            end
        end
    end

    // receiver stall: styles change at random (open, light, heavy,
    // alternating); a requested hold-off overrides them
    int stall_left  = 0;
    int stall_style = 0;
    bit stall_flip  = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(16, 80);
            end
            stall_left--;
            stall_flip = ~stall_flip;
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= stall_flip;
            endcase
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int        i;
        int        ph;
        int        n;
        int        roll;
        int        alloc_pct;
        int        idx;
        int        gap;
        int        burst_left;
        bit        quiet;
        t_in_word  w;
        t_plan_row row;
        logic [8:0] cfg_list [RAND_PHASES];

        // shadow state at reset
        block_count_reg = BPC_RESET;
        next_pick = '0;
        for (i = 0; i < N_SLOTS; i++) begin
            chunk_on[i]   = 1'b0;
            chunk_left[i] = '0;
            chunk_top[i]  = STACK_EMPTY;
            chunk_mark[i] = '0;
        end
        for (i = 0; i < N_SLOTS*SLOT_BLOCKS; i++)
            chain_word[i] = '0;

        // directed plan, one block per chunk so every slot fills fast
        plan_cfg(9'd0);                                             // zero acts as one
        plan_req(MODE_ALLOC, 4'd0, 8'd0, 1'b1, STATUS_OK, 1'b0);    // first word after reset
        for (i = 1; i < N_SLOTS; i++)
            plan_req(MODE_ALLOC, 4'd0, 8'd0, 1'b0, STATUS_OK, 1'b0); // one new slot each
        plan_req(MODE_ALLOC, 4'd0, 8'd0, 1'b1, STATUS_NO_SLOT, 1'b0);  // all slots used up
        plan_req(MODE_FREE, 4'd3, 8'd0, 1'b1, STATUS_OK, 1'b0);     // chunk 3 becomes the spare
        plan_req(MODE_FREE, 4'd5, 8'd0, 1'b1, STATUS_OK, 1'b1);     // second empty chunk released
        plan_req(MODE_FREE, 4'd5, 8'd0, 1'b1, STATUS_BAD_FREE, 1'b0); // chunk now inactive
        plan_req(MODE_FREE, 4'd0, 8'd1, 1'b1, STATUS_BAD_FREE, 1'b0); // block past chunk size
        plan_req(MODE_FREE, 4'd15, 8'd255, 1'b1, STATUS_BAD_FREE, 1'b0); // all-ones handle
        plan_req(MODE_FREE, 4'd3, 8'd0, 1'b1, STATUS_BAD_FREE, 1'b0); // count already full
        plan_req(MODE_ALLOC, 4'd15, 8'd255, 1'b0, STATUS_OK, 1'b0); // pops the spare's stack
        plan_req(MODE_ALLOC, 4'd0, 8'd0, 1'b0, STATUS_OK, 1'b0);    // reopens slot 5
        plan_req(MODE_FREE, 4'd7, 8'd0, 1'b0, STATUS_OK, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_block_count(row.cfg);
            end else begin
                send_request(row.word, row.typed, row.want);
            end
        end

        // random phases over several chunk sizes, extremes included
        cfg_list = '{9'd2, 9'd256, 9'd1, 9'd511, 9'd3, 9'd0, 9'd17, 9'd0};
        cfg_list[5] = 9'($urandom_range(4, 40));
        cfg_list[7] = 9'($urandom_range(0, 511));
        burst_left = 0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            write_block_count(cfg_list[ph]);
            // even phases lean to allocating, odd ones to freeing
            alloc_pct = (ph % 2 == 0) ? 62 : 40;
            for (n = 0; n < PHASE_WORDS; n++) begin
                // long receiver hold-off while the sender keeps pushing
                if (ph == 1 && n == 0)
                    hold_req = 1'b1;
                // sender pause until the pipe is empty
                if (ph == 4 && n == PHASE_WORDS/2)
                    drain_results();

                w.mode       = MODE_FREE;
                w.free_chunk = 4'($urandom_range(0, 15));
                w.free_block = 8'($urandom_range(0, 255));
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct) begin
                    w.mode = MODE_ALLOC;
                end else if (roll < alloc_pct + 32 && freeable.size() != 0) begin
                    idx = $urandom_range(0, freeable.size() - 1);
                    w = freeable[idx];
                    freeable.delete(idx);
                    last_freed = w;
                    have_last = 1'b1;
                end else if (roll < alloc_pct + 37 && have_last) begin
                    // double free of a handle already on its stack
                    w = last_freed;
                end

                // bursts and gaps, none during the hold-off or the no-gap phase
                quiet = (ph == 2) || hold_req || (hold_left != 0);
                if (!quiet) begin
                    if (burst_left == 0) begin
                        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) :
                                                            $urandom_range(0, 4);
                        burst_left = $urandom_range(1, 12);
                        if (gap != 0) begin
                            i_in_valid <= 1'b0;
                            repeat (gap) @(posedge i_clk);
                        end
                    end else begin
                        burst_left--;
                    end
                end
                send_request(w, 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests over %0d chunk sizes: %0d grants, %0d no-slot refusals",
                 n_requests, RAND_PHASES + 1, n_alloc_ok, n_no_slot);
        $display("%0d good frees, %0d bad frees, %0d chunk releases, %0d long hold-offs, %0d words",
                 n_free_ok, n_bad_free, n_released, holds_done, words_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
